// File: design/scalar_kalman_batch_average_core_defines.svh
// Assertion macros shared by the scalar Kalman batch average core.
`ifndef SCALAR_KALMAN_BATCH_AVERAGE_CORE_DEFINES_SVH
`define SCALAR_KALMAN_BATCH_AVERAGE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define SKBA_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Property whose consequent must hold in the cycle after the antecedent.
`define SKBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SKBA_ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define SKBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// File: design/skba_pkg.sv
// Types and constants of the scalar Kalman batch average core.
package skba_pkg;

  localparam int unsigned SAMPLES  = 10;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned REG_W    = 20;
  localparam int unsigned EST_W    = SAMPLE_W + FRAC_W;
  localparam int unsigned COV_W    = 21;
  localparam int unsigned PT_W     = COV_W + 1;
  localparam int unsigned DEN_W    = PT_W + 1;
  localparam int unsigned GAIN_W   = FRAC_W + 1;
  localparam int unsigned MAG_W    = EST_W;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned STEP_W   = $clog2(GAIN_W + 1);

  // Magnitude of the batch sum with the fraction dropped is at most SAMPLES * 128.
  localparam int unsigned MEAN_W   = $clog2(SAMPLES * 128 + 1);
  localparam int unsigned RECIP_SH = 24;
  localparam int unsigned RECIP_W  = RECIP_SH + 1;
  localparam logic [RECIP_W-1:0] RECIP_C =
    RECIP_W'((2 ** RECIP_SH + SAMPLES - 1) / SAMPLES);

  localparam logic [CNT_W-1:0]  SAMPLES_C = CNT_W'(SAMPLES);
  localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(2 ** FRAC_W);

  localparam logic [REG_W-1:0] PROCESS_NOISE_RESET     = REG_W'(1442);
  localparam logic [REG_W-1:0] MEASUREMENT_NOISE_RESET = REG_W'(46989);

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_SEL_BIT = 2;

  typedef enum logic {
    REG_PROCESS_NOISE     = 1'b0,
    REG_MEASUREMENT_NOISE = 1'b1
  } reg_sel_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_start;
    logic mul;
    logic update;
    logic accum;
    logic mean_abs;
    logic mean_mul;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic last;
    logic out_free;
  } status_t;

endpackage

// File: design/skba_div.sv
// Restoring divider that forms the Kalman gain one quotient bit per cycle.
module skba_div import skba_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PT_W-1:0]   num,
  input  logic [DEN_W-1:0]  den,
  output logic              done,
  output logic [GAIN_W-1:0] quot
);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DEN_W:0]    rem;
  logic [DEN_W-1:0]  den_r;
  logic              den_zero;
  logic              take;
  logic [DEN_W:0]    rem_sub;

  // The numerator never exceeds the denominator, so the first step yields the
  // integer bit and the remaining steps the fraction bits.
  assign take    = !den_zero && (rem >= {1'b0, den_r});
  assign rem_sub = take ? (rem - {1'b0, den_r}) : rem;
  assign done    = busy && (step == STEP_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= STEP_W'(GAIN_W);
    end else if (busy) begin
      step <= step - STEP_W'(1);
      if (step == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= {2'b00, num};
      den_r    <= den;
      den_zero <= (den == '0);
      quot     <= '0;
    end else if (busy) begin
      rem  <= {rem_sub[DEN_W-1:0], 1'b0};
      quot <= {quot[GAIN_W-2:0], take};
    end
  end

endmodule

// File: design/skba_dpath.sv
// Datapath of the scalar Kalman batch average core: filter state, multipliers,
// batch sum, mean and output register.
`include "scalar_kalman_batch_average_core_defines.svh"

module skba_dpath import skba_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output status_t             status,
  input  logic [SAMPLE_W-1:0] rssi_sample,
  input  logic [REG_W-1:0]    process_noise,
  input  logic [REG_W-1:0]    measurement_noise,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] average_estimate
);

  logic [EST_W-1:0]          z_in;
  logic [EST_W-1:0]          sample_z;
  logic [EST_W-1:0]          estimate;
  logic [COV_W-1:0]          covariance;
  logic [SUM_W-1:0]          estimate_sum;
  logic [CNT_W-1:0]          sample_count;
  logic [PT_W-1:0]           pt;
  logic [DEN_W-1:0]          denom;
  logic [MAG_W-1:0]          diff_mag;
  logic                      diff_neg;
  logic [MAG_W+GAIN_W-1:0]   corr_prod;
  logic [GAIN_W+PT_W-1:0]    cov_prod;
  logic [MEAN_W-1:0]         mean_mag;
  logic                      mean_neg;
  logic [MEAN_W+RECIP_W-1:0] mean_prod;
  logic [GAIN_W-1:0]         gain;
  logic                      div_done;

  logic [PT_W-1:0]     pt_calc;
  logic [EST_W:0]      diff_calc;
  logic [EST_W:0]      diff_abs;
  logic [MAG_W-1:0]    corr;
  logic [GAIN_W-1:0]   gain_rest;
  logic [SUM_W-1:0]    sum_abs;
  logic [SAMPLE_W-1:0] mean_q;

  assign z_in      = {rssi_sample, {FRAC_W{1'b0}}};
  assign pt_calc   = {1'b0, covariance} + {{(PT_W-REG_W){1'b0}}, process_noise};
  assign diff_calc = {sample_z[EST_W-1], sample_z} - {estimate[EST_W-1], estimate};
  assign diff_abs  = diff_calc[EST_W] ? (~diff_calc + 1'b1) : diff_calc;
  assign corr      = corr_prod[FRAC_W +: MAG_W];
  assign gain_rest = GAIN_ONE - gain;
  assign sum_abs   = estimate_sum[SUM_W-1] ? (~estimate_sum + 1'b1) : estimate_sum;
  assign mean_q    = mean_prod[RECIP_SH +: SAMPLE_W];

  skba_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (pt),
    .den   (denom),
    .done  (div_done),
    .quot  (gain)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_z <= z_in;
      // A new batch restarts from the first sample with zero covariance.
      if (sample_count == '0) begin
        estimate     <= z_in;
        covariance   <= '0;
        estimate_sum <= '0;
      end
    end
    if (cmd.prep) begin
      pt       <= pt_calc;
      denom    <= {1'b0, pt_calc} + {{(DEN_W-REG_W){1'b0}}, measurement_noise};
      diff_mag <= diff_abs[MAG_W-1:0];
      diff_neg <= diff_calc[EST_W];
    end
    if (cmd.mul) begin
      corr_prod <= {{GAIN_W{1'b0}}, diff_mag} * {{MAG_W{1'b0}}, gain};
      cov_prod  <= {{PT_W{1'b0}}, gain_rest} * {{GAIN_W{1'b0}}, pt};
    end
    if (cmd.update) begin
      estimate   <= diff_neg ? (estimate - corr) : (estimate + corr);
      covariance <= cov_prod[FRAC_W +: COV_W];
    end
    if (cmd.accum) begin
      estimate_sum <= estimate_sum + {{(SUM_W-EST_W){estimate[EST_W-1]}}, estimate};
    end
    if (cmd.mean_abs) begin
      mean_mag <= sum_abs[FRAC_W +: MEAN_W];
      mean_neg <= estimate_sum[SUM_W-1];
    end
    if (cmd.mean_mul) begin
      mean_prod <= {{RECIP_W{1'b0}}, mean_mag} * {{MEAN_W{1'b0}}, RECIP_C};
    end
    if (cmd.emit) begin
      average_estimate <= mean_neg ? (~mean_q + 1'b1) : mean_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.emit) begin
        sample_count <= '0;
      end else if (cmd.update) begin
        sample_count <= sample_count + CNT_W'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.div_done = div_done;
  assign status.last     = (sample_count == SAMPLES_C);
  assign status.out_free = !out_valid || out_ready;

  `SKBA_ASSERT_ALWAYS(a_count_range, clk, rst, sample_count <= SAMPLES_C, "sample count beyond batch size")
  `SKBA_ASSERT_ALWAYS(a_gain_range, clk, rst, !cmd.mul || (gain <= GAIN_ONE), "gain above one")
  `SKBA_ASSERT_NEXT(a_emit_restart, clk, rst, cmd.emit, out_valid && (sample_count == '0), "batch not restarted after mean")

endmodule

// File: design/skba_ctrl.sv
// Controller state machine that sequences each sample, and each batch mean, through the datapath.
`include "scalar_kalman_batch_average_core_defines.svh"

module skba_ctrl import skba_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b0000000001,
    ST_PREP      = 10'b0000000010,
    ST_DIV_START = 10'b0000000100,
    ST_DIV_WAIT  = 10'b0000001000,
    ST_MUL       = 10'b0000010000,
    ST_UPDATE    = 10'b0000100000,
    ST_ACCUM     = 10'b0001000000,
    ST_MEAN_ABS  = 10'b0010000000,
    ST_MEAN_MUL  = 10'b0100000000,
    ST_EMIT      = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_DIV_START;
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = status.last ? ST_MEAN_ABS : ST_IDLE;
      end
      ST_MEAN_ABS: begin
        cmd.mean_abs = 1'b1;
        state_next   = ST_MEAN_MUL;
      end
      ST_MEAN_MUL: begin
        cmd.mean_mul = 1'b1;
        state_next   = ST_EMIT;
      end
      ST_EMIT: begin
        // Hold the mean until the output register is free.
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `SKBA_ASSERT_ALWAYS(a_emit_free, clk, rst, !cmd.emit || status.out_free, "mean written over a pending result")
  `SKBA_ASSERT_NEXT(a_div_to_mul, clk, rst, (state == ST_DIV_WAIT) && status.div_done, state == ST_MUL, "divider completion missed")
  `SKBA_ASSERT_NEXT(a_last_to_mean, clk, rst, (state == ST_ACCUM) && status.last, state == ST_MEAN_ABS, "batch end missed")

endmodule

// File: design/scalar_kalman_batch_average_core.sv
// Top level of the scalar Kalman batch average core with its register port.
// The 17-step gain divider takes most of the time from each accepted sample transfer
// to the next possible transfer.
// After the last sample of a batch the controller also forms the mean and writes it
// to the output register once that register is free.
// Synchronous reset clears the controller, the sample count and the output valid,
// and loads the noise registers with their defaults.
module scalar_kalman_batch_average_core import skba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] rssi_sample
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // [7:0] average_estimate
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [REG_W-1:0] process_noise;
  logic [REG_W-1:0] measurement_noise;
  logic             reg_write;
  reg_sel_t         reg_sel;
  cmd_t             cmd;
  status_t          status;

  // The register port never stalls. Process noise lives at byte address 0 and
  // measurement noise at byte address 4; only the low 20 data bits are kept.
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;
  assign reg_sel   = reg_sel_t'(paddr[REG_SEL_BIT]);

  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise     <= PROCESS_NOISE_RESET;
      measurement_noise <= MEASUREMENT_NOISE_RESET;
    end else if (reg_write) begin
      case (reg_sel)
        REG_PROCESS_NOISE: begin
          process_noise <= pwdata[REG_W-1:0];
        end
        REG_MEASUREMENT_NOISE: begin
          measurement_noise <= pwdata[REG_W-1:0];
        end
        default: begin
          process_noise <= process_noise;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PROCESS_NOISE: begin
        prdata = {{(APB_DATA_W-REG_W){1'b0}}, process_noise};
      end
      REG_MEASUREMENT_NOISE: begin
        prdata = {{(APB_DATA_W-REG_W){1'b0}}, measurement_noise};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  // The controller takes a sample only when idle and then steps the datapath
  // through the covariance prediction, gain division, correction and batch sum.
  skba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the result in its own output register, so a finished
  // mean may wait for the sink while the next batch is already being filtered.
  skba_dpath u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .rssi_sample       (s_tdata),
    .process_noise     (process_noise),
    .measurement_noise (measurement_noise),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .average_estimate  (m_tdata)
  );

endmodule
